>>> src/lsgc_pkg.sv
// Shared types and constants for the line shading gain calibrator.
// No dependencies.
`default_nettype none
package lsgc_pkg;

  // request codes on req_type_i
  typedef enum logic [1:0] {
    REQ_PIXEL    = 2'd0,
    REQ_FINALIZE = 2'd1,
    REQ_LOOKUP   = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_e;

  // configuration register indexes
  localparam logic [2:0] CFG_RANGE_START = 3'd0;
  localparam logic [2:0] CFG_RANGE_END   = 3'd1;
  localparam logic [2:0] CFG_TARGET_R    = 3'd2;
  localparam logic [2:0] CFG_TARGET_G    = 3'd3;
  localparam logic [2:0] CFG_TARGET_B    = 3'd4;
  localparam logic [2:0] CFG_LAYER_CNT   = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOT_FINL = 2'd2;

  localparam logic [15:0] UNITY_GAIN = 16'd4096;
  localparam logic [15:0] GAIN_MAX   = 16'hFFFF;
  localparam logic [23:0] COUNT_MAX  = 24'hFFFFFF;
  localparam int          LAYERS     = 3;
  // column comparisons are done at this width
  localparam int          CMPW       = 16;

endpackage
`default_nettype wire

>>> src/line_shading_gain_calibrator_unit.sv
// Line shading gain calibrator: per-column statistics, gain finalize, lookup.
// Depends on lsgc_pkg.
`default_nettype none
//
// channel   | direction | signals
// ----------+-----------+-----------------------------------------------
// request   | in        | start_i / busy_o, req_type_i, column_i, samples
// result    | out       | done_o strobe, corrected_o, avg_*_o, status_o
// config    | in        | cfg_we_i, cfg_idx_i, cfg_data_i
//
// A pixel reads then writes the statistics memory. A lookup reads the gain
// memory and registers its result, strobed on done_o. Clear sweeps the
// statistics memory. Finalize walks the in-range columns through the
// one-bit-per-cycle shared divider, then fills the edge columns and divides
// for the global averages. After reset a clearing pass fills both memories;
// busy_o is high meanwhile. Results cannot be stalled.
module line_shading_gain_calibrator_unit
  import lsgc_pkg::*;
#(
  parameter int COLUMNS = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [11:0] column_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  input  wire logic [1:0]  layer_i,
  input  wire logic [7:0]  brightness_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output logic             done_o,
  output logic [7:0]       corrected_o,
  output logic [15:0]      avg_red_o,
  output logic [15:0]      avg_green_o,
  output logic [15:0]      avg_blue_o,
  output logic [1:0]       status_o
);

  localparam int AW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int TSW  = 33 + $clog2(COLUMNS);
  localparam int TCW  = 25 + $clog2(COLUMNS);
  localparam int DW   = TSW + 8;
  localparam int VW   = TSW;
  localparam int CNTW = $clog2(DW + 1);
  localparam int STW  = 24 + 32 * LAYERS;
  localparam int GW   = 16 * LAYERS;
  localparam logic [CMPW-1:0] COLS_C = CMPW'(COLUMNS);
  localparam logic [AW-1:0]   XLAST  = AW'(COLUMNS - 1);

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_INIT = 14'b00000000000010,
    S_CLR  = 14'b00000000000100,
    S_PIX  = 14'b00000000001000,
    S_LOOK = 14'b00000000010000,
    S_FRD  = 14'b00000000100000,
    S_FLAT = 14'b00000001000000,
    S_FLAY = 14'b00000010000000,
    S_DIV1 = 14'b00000100000000,
    S_DIV2 = 14'b00001000000000,
    S_FWR  = 14'b00010000000000,
    S_FILL = 14'b00100000000000,
    S_GAVG = 14'b01000000000000,
    S_FOUT = 14'b10000000000000
  } state_e;

  // configuration registers
  logic [12:0] range_start_q, range_end_q;
  logic [15:0] target_q [LAYERS];
  logic [1:0]  layer_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_start_q <= 13'd0;
      range_end_q   <= 13'd4096;
      target_q[0]   <= 16'd32768;
      target_q[1]   <= 16'd32768;
      target_q[2]   <= 16'd32768;
      layer_cnt_q   <= 2'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE_START: range_start_q <= cfg_data_i[12:0];
        CFG_RANGE_END:   range_end_q   <= cfg_data_i[12:0];
        CFG_TARGET_R:    target_q[0]   <= cfg_data_i;
        CFG_TARGET_G:    target_q[1]   <= cfg_data_i;
        CFG_TARGET_B:    target_q[2]   <= cfg_data_i;
        CFG_LAYER_CNT:   layer_cnt_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // derived range and layer settings
  logic [CMPW-1:0] start_c, end_raw, end_c, col_c;
  logic [1:0]      nl;
  logic            empty_range;
  logic [AW-1:0]   col_idx;
  assign start_c     = CMPW'(range_start_q);
  assign end_raw     = CMPW'(range_end_q);
  assign end_c       = (end_raw > COLS_C) ? COLS_C : end_raw;
  assign nl          = (layer_cnt_q == 2'd0) ? 2'd1 : layer_cnt_q;
  assign empty_range = start_c >= end_c;
  assign col_c       = CMPW'(column_i);
  assign col_idx     = (col_c >= COLS_C) ? XLAST : col_c[AW-1:0];

  // state registers
  state_e          state_q, state_d;
  logic [AW-1:0]   x_q, x_d;
  logic [1:0]      lay_q, lay_d;
  logic [STW-1:0]  stats_q, stats_d;
  logic [GW-1:0]   gw_q, gw_d, g_first_q, g_first_d, g_last_q, g_last_d;
  logic [TSW-1:0]  tsum_q [LAYERS];
  logic [TSW-1:0]  tsum_d [LAYERS];
  logic [TCW-1:0]  tcnt_q, tcnt_d;
  logic            empty_q, empty_d, ready_q, ready_d, pix_ok_q, pix_ok_d;
  logic [15:0]     avg_q [LAYERS];
  logic [15:0]     avg_d [LAYERS];
  logic [23:0]     samp_q, samp_d;
  logic [1:0]      lkl_q, lkl_d;
  logic [7:0]      bri_q, bri_d;
  logic            done_q, done_d;
  logic [7:0]      corr_q, corr_d;
  logic [15:0]     ao_q [LAYERS];
  logic [15:0]     ao_d [LAYERS];
  logic [1:0]      status_q, status_d;

  // memories: statistics {sums, count} and gains, one word per column
  logic [STW-1:0] st_mem [COLUMNS];
  logic [GW-1:0]  g_mem  [COLUMNS];
  logic [STW-1:0] st_rdata_q, st_wdata;
  logic [GW-1:0]  g_rdata_q, g_wdata;
  logic [AW-1:0]  addr;
  logic           st_we, g_we;

  assign addr = (state_q == S_IDLE) ? col_idx : x_q;

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[addr] <= st_wdata;
    st_rdata_q <= st_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (g_we) g_mem[addr] <= g_wdata;
    g_rdata_q <= g_mem[addr];
  end

  // shared restoring divider, one quotient bit per cycle
  logic            div_ld;
  logic [DW-1:0]   div_dvd_in, div_dvd_q;
  logic [VW-1:0]   div_dvs_in, div_dvs_q, div_rem_q;
  logic [CNTW-1:0] div_cnt_q;
  logic [VW:0]     rem_sh, rem_diff;
  logic            rem_ge;
  assign rem_sh   = {div_rem_q, div_dvd_q[DW-1]};
  assign rem_diff = rem_sh - {1'b0, div_dvs_q};
  assign rem_ge   = rem_sh >= {1'b0, div_dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_ld) begin
      div_cnt_q <= CNTW'(DW);
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ld) begin
      div_dvd_q <= div_dvd_in;
      div_dvs_q <= div_dvs_in;
      div_rem_q <= '0;
    end else if (div_cnt_q != '0) begin
      div_rem_q <= rem_ge ? rem_diff[VW-1:0] : rem_sh[VW-1:0];
      div_dvd_q <= {div_dvd_q[DW-2:0], rem_ge};
    end
  end

  // per-layer views of the latched statistics word
  logic [23:0] st_cnt;
  logic [31:0] st_sum, lay_avg;
  logic [15:0] lay_tgt;
  logic        last_lay, div_done, q_sat;
  assign st_cnt   = stats_q[23:0];
  assign st_sum   = stats_q[24 + 32 * lay_q +: 32];
  assign lay_tgt  = target_q[lay_q];
  assign lay_avg  = div_dvd_q[31:0];
  assign last_lay = lay_q == 2'(LAYERS - 1);
  assign div_done = div_cnt_q == '0;
  assign q_sat    = |div_dvd_q[DW-1:16];

  // lookup product
  logic [15:0] lk_gain;
  logic [23:0] lk_prod;
  assign lk_gain = g_rdata_q[16 * ((lkl_q == 2'd3) ? 2'd2 : lkl_q) +: 16];
  assign lk_prod = 24'(bri_q) * 24'(lk_gain);

  // pixel update word
  logic [STW-1:0] pix_word;
  always_comb begin
    pix_word        = st_rdata_q;
    pix_word[23:0]  = st_rdata_q[23:0] + 24'd1;
    for (int l = 0; l < LAYERS; l++) begin
      if (2'(l) < nl) begin
        pix_word[24 + 32 * l +: 32] = st_rdata_q[24 + 32 * l +: 32] + 32'(samp_q[8 * l +: 8]);
      end
    end
  end

  // marks that the divider runs for the global averages
  logic gavg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gavg_q <= 1'b0;
    end else if (state_q == S_GAVG) begin
      gavg_q <= 1'b1;
    end else if (state_q == S_FOUT || state_q == S_IDLE) begin
      gavg_q <= 1'b0;
    end
  end

  // control
  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    lay_d      = lay_q;
    stats_d    = stats_q;
    gw_d       = gw_q;
    g_first_d  = g_first_q;
    g_last_d   = g_last_q;
    tsum_d     = tsum_q;
    tcnt_d     = tcnt_q;
    empty_d    = empty_q;
    ready_d    = ready_q;
    pix_ok_d   = pix_ok_q;
    avg_d      = avg_q;
    samp_d     = samp_q;
    lkl_d      = lkl_q;
    bri_d      = bri_q;
    done_d     = 1'b0;
    corr_d     = corr_q;
    ao_d       = ao_q;
    status_d   = status_q;
    st_we      = 1'b0;
    g_we       = 1'b0;
    st_wdata   = '0;
    g_wdata    = {LAYERS{UNITY_GAIN}};
    div_ld     = 1'b0;
    div_dvd_in = DW'(st_sum) << 8;
    div_dvs_in = VW'(st_cnt);

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_d = col_idx;
          case (req_type_i)
            REQ_PIXEL: begin
              pix_ok_d = col_c < COLS_C && col_c >= start_c && col_c < end_c;
              samp_d   = {blue_i, green_i, red_i};
              state_d  = S_PIX;
            end
            REQ_LOOKUP: begin
              lkl_d   = layer_i;
              bri_d   = brightness_i;
              state_d = S_LOOK;
            end
            REQ_CLEAR: begin
              x_d     = '0;
              state_d = S_CLR;
            end
            default: begin
              empty_d   = empty_range;
              tcnt_d    = '0;
              for (int l = 0; l < LAYERS; l++) tsum_d[l] = '0;
              g_first_d = {LAYERS{UNITY_GAIN}};
              g_last_d  = {LAYERS{UNITY_GAIN}};
              if (empty_range) begin
                x_d     = '0;
                state_d = S_FILL;
              end else begin
                x_d     = start_c[AW-1:0];
                state_d = S_FRD;
              end
            end
          endcase
        end
      end
      S_INIT: begin
        st_we = 1'b1;
        g_we  = 1'b1;
        x_d   = x_q + 1'b1;
        if (x_q == XLAST) state_d = S_IDLE;
      end
      S_CLR: begin
        st_we = 1'b1;
        x_d   = x_q + 1'b1;
        if (x_q == XLAST) state_d = S_IDLE;
      end
      S_PIX: begin
        st_wdata = pix_word;
        st_we    = pix_ok_q && (st_rdata_q[23:0] != COUNT_MAX);
        state_d  = S_IDLE;
      end
      S_LOOK: begin
        done_d   = 1'b1;
        corr_d   = (|lk_prod[23:20]) ? 8'hFF : lk_prod[19:12];
        for (int l = 0; l < LAYERS; l++) ao_d[l] = '0;
        status_d = !ready_q ? ST_NOT_FINL : (empty_q ? ST_EMPTY : ST_OK);
        state_d  = S_IDLE;
      end
      S_FRD: state_d = S_FLAT;
      S_FLAT: begin
        stats_d = st_rdata_q;
        lay_d   = '0;
        state_d = S_FLAY;
      end
      S_FLAY: begin
        if (lay_q >= nl) begin
          gw_d[16 * lay_q +: 16] = UNITY_GAIN;
          lay_d   = lay_q + 1'b1;
          if (last_lay) state_d = S_FWR;
        end else begin
          tsum_d[lay_q] = tsum_q[lay_q] + TSW'(st_sum);
          if (lay_q == 2'd0) tcnt_d = tcnt_q + TCW'(st_cnt);
          if (st_cnt == 24'd0) begin
            gw_d[16 * lay_q +: 16] = UNITY_GAIN;
            empty_d = 1'b1;
            lay_d   = lay_q + 1'b1;
            if (last_lay) state_d = S_FWR;
          end else begin
            div_ld  = 1'b1;
            state_d = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (div_done) begin
          if (lay_avg == 32'd0) begin
            gw_d[16 * lay_q +: 16] = GAIN_MAX;
            lay_d   = lay_q + 1'b1;
            state_d = last_lay ? S_FWR : S_FLAY;
          end else begin
            div_ld     = 1'b1;
            div_dvd_in = DW'(lay_tgt) << 12;
            div_dvs_in = VW'(lay_avg);
            state_d    = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (div_done) begin
          gw_d[16 * lay_q +: 16] = q_sat ? GAIN_MAX : div_dvd_q[15:0];
          lay_d   = lay_q + 1'b1;
          state_d = last_lay ? S_FWR : S_FLAY;
        end
      end
      S_FWR: begin
        g_we     = 1'b1;
        g_wdata  = gw_q;
        g_last_d = gw_q;
        if (CMPW'(x_q) == start_c) g_first_d = gw_q;
        if (CMPW'(x_q) == end_c - 1'b1) begin
          x_d     = '0;
          state_d = S_FILL;
        end else begin
          x_d     = x_q + 1'b1;
          state_d = S_FRD;
        end
      end
      S_FILL: begin
        g_we    = CMPW'(x_q) < start_c || CMPW'(x_q) >= end_c;
        g_wdata = (CMPW'(x_q) < start_c) ? g_first_q : g_last_q;
        x_d     = x_q + 1'b1;
        if (x_q == XLAST) begin
          lay_d   = '0;
          state_d = S_GAVG;
        end
      end
      S_GAVG: begin
        // one division per layer in use over the whole range
        if (div_ld == 1'b0 && div_done && lay_q != 2'd3 && !(lay_q[0] & lay_q[1])) begin
          if (lay_q < nl && tcnt_q != '0 && !empty_range) begin
            div_ld     = 1'b1;
            div_dvd_in = DW'(tsum_q[lay_q]) << 8;
            div_dvs_in = VW'(tcnt_q);
            lay_d      = lay_q | 2'd0;
            state_d    = S_DIV2;
            x_d        = '1;
          end else begin
            avg_d[lay_q] = '0;
            lay_d   = lay_q + 1'b1;
            if (last_lay) state_d = S_FOUT;
          end
        end
      end
      S_FOUT: begin
        done_d   = 1'b1;
        corr_d   = '0;
        ao_d     = avg_q;
        status_d = empty_q ? ST_EMPTY : ST_OK;
        ready_d  = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // global average division returns through S_DIV2 with x_q all ones and
    // the walk already done; route its quotient to the averages
    if (state_q == S_DIV2 && div_done && gavg_q) begin
      gw_d         = gw_q;
      avg_d[lay_q] = q_sat ? GAIN_MAX : div_dvd_q[15:0];
      lay_d        = lay_q + 1'b1;
      state_d      = last_lay ? S_FOUT : S_GAVG;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      x_q      <= '0;
      lay_q    <= '0;
      empty_q  <= 1'b0;
      ready_q  <= 1'b0;
      done_q   <= 1'b0;
      pix_ok_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      x_q      <= x_d;
      lay_q    <= lay_d;
      empty_q  <= empty_d;
      ready_q  <= ready_d;
      done_q   <= done_d;
      pix_ok_q <= pix_ok_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    stats_q   <= stats_d;
    gw_q      <= gw_d;
    g_first_q <= g_first_d;
    g_last_q  <= g_last_d;
    tsum_q    <= tsum_d;
    tcnt_q    <= tcnt_d;
    avg_q     <= avg_d;
    samp_q    <= samp_d;
    lkl_q     <= lkl_d;
    bri_q     <= bri_d;
    corr_q    <= corr_d;
    ao_q      <= ao_d;
    status_q  <= status_d;
  end

  assign busy_o      = state_q != S_IDLE;
  assign done_o      = done_q;
  assign corrected_o = corr_q;
  assign avg_red_o   = ao_q[0];
  assign avg_green_o = ao_q[1];
  assign avg_blue_o  = ao_q[2];
  assign status_o    = status_q;

  // a result follows only a lookup or the end of a finalize
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_LOOK || $past(state_q) == S_FOUT))
    else $error("result without a lookup or finalize");

  // no memory write while waiting for requests
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !st_we && !g_we)
    else $error("memory write while idle");

  // the divider runs only in a division state
  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_cnt_q != '0 |-> (state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider running outside a division state");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for line_shading_gain_calibrator_unit: a clocked driver
// fed from a queue of pending requests, a result monitor and a per-column gain predictor.
// Depends on lsgc_pkg and the unit under test.
`timescale 1ns / 1ps
module tb_top;
  import lsgc_pkg::*;

  localparam int COLS       = 4096;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE     = 16;

  typedef struct packed {
    req_e        kind;
    logic [11:0] col;
    logic [7:0]  r, g, b;
    logic [1:0]  lay;
    logic [7:0]  bright;
  } shading_req_t;

  typedef struct packed {
    logic [7:0]  corrected;
    logic [15:0] avg_r, avg_g, avg_b;
    logic [1:0]  status;
  } gain_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  req_type_i;
  logic [11:0] column_i;
  logic [7:0]  red_i, green_i, blue_i;
  logic [1:0]  layer_i;
  logic [7:0]  brightness_i;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        done_o;
  logic [7:0]  corrected_o;
  logic [15:0] avg_red_o, avg_green_o, avg_blue_o;
  logic [1:0]  status_o;

  line_shading_gain_calibrator_unit #(.COLUMNS(COLS)) u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_type_i, .column_i, .red_i, .green_i,
    .blue_i, .layer_i, .brightness_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_o,
    .corrected_o, .avg_red_o, .avg_green_o, .avg_blue_o, .status_o
  );

  always #1 clk_i = ~clk_i;

  // queues and counters
  shading_req_t pend_q[$];
  gain_result_t exp_q[$];
  int n_sent, n_checked, n_fail, n_final, n_lookup;
  int cycles;

  // predictor state and configuration
  logic [31:0] sum_mem  [3*COLS];
  logic [23:0] cnt_mem  [COLS];
  logic [15:0] gain_mem [3*COLS];
  bit          ready_q, empty_q;
  logic [12:0] rs_q, re_q;
  logic [15:0] tgt_q [3];
  logic [1:0]  lc_q;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
    n_fail++;
  endtask

  function automatic logic [15:0] gain_for(logic [15:0] tgt, longint unsigned avg);
    longint unsigned q;
    if (avg == 0) return GAIN_MAX;
    q = (longint'(tgt) * 4096) / avg;
    return (q > 65535) ? GAIN_MAX : q[15:0];
  endfunction

  task automatic clear_stats();
    for (int i = 0; i < 3*COLS; i++) sum_mem[i] = '0;
    for (int i = 0; i < COLS; i++) cnt_mem[i] = '0;
  endtask

  // finalize: per-column gains, edge fill, global averages
  task automatic predict_finalize();
    gain_result_t res;
    int unsigned lo, hi, nl;
    bit empty_rng;
    longint unsigned tsum, tcnt, a, avg;
    logic [15:0] avgs [3];
    lo = rs_q;
    hi = (re_q > COLS) ? COLS : re_q;
    nl = (lc_q == 0) ? 1 : lc_q;
    empty_rng = (lo >= hi);
    empty_q = empty_rng;
    for (int lay = 0; lay < 3; lay++) begin
      avgs[lay] = '0;
      if (lay >= nl || empty_rng) begin
        for (int x = 0; x < COLS; x++) gain_mem[lay*COLS + x] = UNITY_GAIN;
        continue;
      end
      tsum = 0;
      tcnt = 0;
      for (int x = lo; x < hi; x++) begin
        if (cnt_mem[x] == 0) begin
          gain_mem[lay*COLS + x] = UNITY_GAIN;
          empty_q = 1'b1;
        end else begin
          avg = (longint'(sum_mem[lay*COLS + x]) * 256) / cnt_mem[x];
          avg = avg & 64'hFFFF_FFFF;
          gain_mem[lay*COLS + x] = gain_for(tgt_q[lay], avg);
        end
        tsum += sum_mem[lay*COLS + x];
        tcnt += cnt_mem[x];
      end
      for (int x = 0; x < lo; x++) gain_mem[lay*COLS + x] = gain_mem[lay*COLS + lo];
      for (int x = hi; x < COLS; x++) gain_mem[lay*COLS + x] = gain_mem[lay*COLS + hi - 1];
      if (tcnt != 0) begin
        a = (tsum * 256) / tcnt;
        avgs[lay] = (a > 65535) ? 16'hFFFF : a[15:0];
      end
    end
    ready_q = 1'b1;
    res.corrected = '0;
    res.avg_r = avgs[0];
    res.avg_g = avgs[1];
    res.avg_b = avgs[2];
    res.status = empty_q ? ST_EMPTY : ST_OK;
    exp_q.push_back(res);
  endtask

  task automatic predict_request(shading_req_t it);
    gain_result_t res;
    int unsigned nl, lay, v;
    logic [7:0] smp [3];
    case (it.kind)
      REQ_PIXEL: begin
        nl = (lc_q == 0) ? 1 : lc_q;
        smp[0] = it.r; smp[1] = it.g; smp[2] = it.b;
        if (it.col < COLS && it.col >= rs_q && it.col < ((re_q > COLS) ? COLS : re_q)
            && cnt_mem[it.col] < COUNT_MAX) begin
          for (int l = 0; l < nl && l < 3; l++)
            sum_mem[l*COLS + it.col] = sum_mem[l*COLS + it.col] + 32'(smp[l]);
          cnt_mem[it.col] = cnt_mem[it.col] + 24'd1;
        end
      end
      REQ_FINALIZE: predict_finalize();
      REQ_LOOKUP: begin
        lay = (it.lay > 2) ? 2 : it.lay;
        v = (it.bright * gain_mem[lay*COLS + it.col]) >> 12;
        res = '0;
        res.corrected = (v > 255) ? 8'd255 : v[7:0];
        res.status = !ready_q ? ST_NOT_FINL : (empty_q ? ST_EMPTY : ST_OK);
        exp_q.push_back(res);
      end
      default: clear_stats();
    endcase
  endtask

  // driver: bursts of requests with random gaps
  shading_req_t cur;
  int burst_left, gap_left;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_request(cur);
        n_sent++;
      end
      if (!start_i || !busy_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start_i  <= 1'b0;
        end else if (pend_q.size() != 0) begin
          cur          <= pend_q[0];
          req_type_i   <= pend_q[0].kind;
          column_i     <= pend_q[0].col;
          red_i        <= pend_q[0].r;
          green_i      <= pend_q[0].g;
          blue_i       <= pend_q[0].b;
          layer_i      <= pend_q[0].lay;
          brightness_i <= pend_q[0].bright;
          void'(pend_q.pop_front());
          start_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare every strobed result with the oldest expectation
  always @(posedge clk_i) begin
    gain_result_t want;
    if (rst_ni && done_o) begin
      if (exp_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = exp_q.pop_front();
        if (corrected_o !== want.corrected) report_mismatch("corrected", corrected_o, want.corrected);
        if (avg_red_o !== want.avg_r) report_mismatch("avg_red", avg_red_o, want.avg_r);
        if (avg_green_o !== want.avg_g) report_mismatch("avg_green", avg_green_o, want.avg_g);
        if (avg_blue_o !== want.avg_b) report_mismatch("avg_blue", avg_blue_o, want.avg_b);
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
      end
      n_checked++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic add_req(req_e k, int col, int r, int g, int b, int lay, int br);
    shading_req_t it;
    it.kind = k; it.col = 12'(col); it.r = 8'(r); it.g = 8'(g); it.b = 8'(b);
    it.lay = 2'(lay); it.bright = 8'(br);
    pend_q.push_back(it);
    if (k == REQ_FINALIZE) n_final++;
    if (k == REQ_LOOKUP) n_lookup++;
  endtask

  task automatic add_rand_lookup(int col);
    add_req(REQ_LOOKUP, col, $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(0, 255), $urandom_range(0, 3), $urandom_range(0, 255));
  endtask

  // block is idle: nothing queued, nothing expected, busy low
  task automatic wait_idle();
    @(negedge clk_i);
    while (pend_q.size() != 0 || start_i || exp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
  endtask

  task automatic set_regs(int rs, int re, int tr, int tg, int tb, int lc);
    logic [15:0] vals [6];
    vals[0] = 16'(rs); vals[1] = 16'(re); vals[2] = 16'(tr); vals[3] = 16'(tg);
    vals[4] = 16'(tb); vals[5] = 16'(lc);
    wait_idle();
    for (int i = 0; i < 6; i++) begin
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[2:0];
      cfg_data_i <= vals[i];
      case (i[2:0])
        CFG_RANGE_START: rs_q = vals[i][12:0];
        CFG_RANGE_END:   re_q = vals[i][12:0];
        CFG_TARGET_R:    tgt_q[0] = vals[i];
        CFG_TARGET_G:    tgt_q[1] = vals[i];
        CFG_TARGET_B:    tgt_q[2] = vals[i];
        default:         lc_q = vals[i][1:0];
      endcase
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int rs, width, re, mode, npix, col, hi_v, total;
    start_i <= 1'b0; req_type_i <= REQ_PIXEL; column_i <= '0; red_i <= '0; green_i <= '0;
    blue_i <= '0; layer_i <= '0; brightness_i <= '0;
    cfg_we_i <= 1'b0; cfg_idx_i <= '0; cfg_data_i <= '0;
    rst_ni = 1'b0;
    n_sent = 0; n_checked = 0; n_fail = 0; n_final = 0; n_lookup = 0; cycles = 0;
    burst_left = 1; gap_left = 0;
    rs_q = 0; re_q = 4096; tgt_q[0] = 32768; tgt_q[1] = 32768; tgt_q[2] = 32768; lc_q = 3;
    clear_stats();
    for (int i = 0; i < 3*COLS; i++) gain_mem[i] = UNITY_GAIN;
    ready_q = 0; empty_q = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // lookups before any finalize, layer three, last column
    add_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 255);
    add_req(REQ_LOOKUP, 4095, 255, 255, 255, 3, 200);
    // a few columns, layer count zero, extreme targets, one empty column
    set_regs(10, 14, 65535, 0, 32768, 0);
    add_req(REQ_PIXEL, 10, 255, 255, 255, 0, 0);
    add_req(REQ_PIXEL, 10, 0, 0, 0, 0, 0);
    add_req(REQ_PIXEL, 11, 1, 2, 3, 0, 0);
    add_req(REQ_PIXEL, 13, 0, 0, 0, 0, 0);
    add_req(REQ_PIXEL, 9, 255, 255, 255, 0, 0);
    add_req(REQ_PIXEL, 14, 255, 255, 255, 0, 0);
    add_req(REQ_FINALIZE, 0, 0, 0, 0, 0, 0);
    add_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 255);
    add_req(REQ_LOOKUP, 11, 0, 0, 0, 0, 255);
    add_req(REQ_LOOKUP, 12, 0, 0, 0, 0, 100);
    add_req(REQ_LOOKUP, 13, 0, 0, 0, 0, 1);
    add_req(REQ_LOOKUP, 4000, 0, 0, 0, 1, 0);
    // clipped range end at the top columns, all layers
    set_regs(4093, 8191, 0, 65535, 1, 3);
    add_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0);
    add_req(REQ_PIXEL, 4095, 255, 0, 128, 0, 0);
    add_req(REQ_PIXEL, 4094, 7, 255, 0, 0, 0);
    add_req(REQ_PIXEL, 4093, 100, 100, 100, 0, 0);
    add_req(REQ_FINALIZE, 0, 0, 0, 0, 0, 0);
    add_req(REQ_LOOKUP, 5, 0, 0, 0, 2, 255);
    add_req(REQ_LOOKUP, 4095, 0, 0, 0, 1, 255);
    // empty range
    set_regs(100, 50, 32768, 32768, 32768, 2);
    add_req(REQ_FINALIZE, 0, 0, 0, 0, 0, 0);
    add_req(REQ_LOOKUP, 75, 0, 0, 0, 0, 255);

    // random phases: small ranges, well-formed accumulate / finalize / lookup runs
    total = 0;
    while (total < 900) begin
      case ($urandom_range(0, 9))
        0:       rs = 4096;
        1:       rs = 0;
        default: rs = $urandom_range(0, 4095);
      endcase
      width = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 10);
      re = ($urandom_range(0, 7) == 0) ? $urandom_range(4096, 8191) : rs + width;
      if ($urandom_range(0, 9) == 0) re = $urandom_range(0, 8191);
      set_regs(rs, re, $urandom_range(0, 65535), $urandom_range(0, 65535),
               ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(0, 65535),
               $urandom_range(0, 3));
      if ($urandom_range(0, 2) != 0) begin
        add_req(REQ_CLEAR, $urandom_range(0, 4095), 0, 0, 0, 0, 0);
        total++;
      end
      mode = $urandom_range(0, 3);
      hi_v = (mode == 0) ? 3 : 255;
      npix = $urandom_range(10, 60);
      for (int p = 0; p < npix; p++) begin
        if ($urandom_range(0, 4) == 0) col = $urandom_range(0, 4095);
        else col = (rs + $urandom_range(0, (width > 0) ? width - 1 : 0)) % 4096;
        add_req(REQ_PIXEL, col, $urandom_range(0, hi_v), $urandom_range(0, hi_v),
                $urandom_range(0, hi_v), $urandom_range(0, 3), $urandom_range(0, 255));
        if ($urandom_range(0, 60) == 0) add_rand_lookup($urandom_range(0, 4095));
      end
      add_req(REQ_FINALIZE, $urandom_range(0, 4095), 0, 0, 0, 0, 0);
      for (int k = 0; k < 15; k++) begin
        case ($urandom_range(0, 3))
          0:       add_rand_lookup($urandom_range(0, 4095));
          1:       add_rand_lookup((rs > 0) ? rs - 1 : 0);
          2:       add_rand_lookup((re > 0 && re <= 4096) ? re % 4096 : 4095);
          default: add_rand_lookup((rs + $urandom_range(0, 9)) % 4096);
        endcase
      end
      total += npix + 16;
    end

    wait_idle();
    repeat (50) @(posedge clk_i);
    $display("Sent %0d requests (%0d finalize, %0d lookup); checked %0d results",
             n_sent, n_final, n_lookup, n_checked);
    $display("Ranges covered small, clipped, empty and full-edge cases, mismatches: %0d", n_fail);
    if (n_fail == 0 && exp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
